>>> rtl/key_debounce_press_timer_macros.svh
// ============================================================================
// Assertion macros for the key debounce press timer
// Concurrent checks sampled on clk and held off while rst_n is low.
// ============================================================================
`ifndef KEY_DEBOUNCE_PRESS_TIMER_MACROS_SVH
`define KEY_DEBOUNCE_PRESS_TIMER_MACROS_SVH

`ifndef SYNTHESIS

`define KDPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdpt: same-cycle check failed");

`define KDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdpt: next-cycle check failed");

`else

`define KDPT_ASSERT_SAME(label, ante, cons)

`define KDPT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/kdpt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kdpt_pkg
// Shared types and codes of the key debounce press timer.
// ============================================================================
package kdpt_pkg;

  localparam int DUR_BITS = 32;

  localparam logic FUNC_POLL  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_UP      = 4'b0001,
    ST_FALLING = 4'b0010,
    ST_DOWN    = 4'b0100,
    ST_RISING  = 4'b1000
  } kdpt_state_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } kdpt_event_t;

  typedef struct packed {
    kdpt_state_t         st;
    logic [DUR_BITS-1:0] dur;
    logic                flag;
  } kdpt_rec_t;

  localparam kdpt_rec_t REC_RESET = '{st: ST_UP, dur: '0, flag: 1'b0};

  typedef struct packed {
    kdpt_rec_t   rec;
    logic        stamp_we;
    kdpt_event_t ev;
  } kdpt_upd_t;

endpackage

>>> rtl/kdpt_key_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// kdpt_key_mem
// Per-key record memory (debounce state, duration, flag) with registered
// read, per-entry valid bits and write-back bypass.
// ============================================================================
module kdpt_key_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output kdpt_pkg::kdpt_rec_t rd_q,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  kdpt_pkg::kdpt_rec_t wr_data
);
  import kdpt_pkg::*;

  kdpt_rec_t        mem [DEPTH];
  kdpt_rec_t        mem_q_r;
  kdpt_rec_t        byp_r;
  logic [DEPTH-1:0] valid_r;
  logic             hit_r;
  logic             vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      byp_r   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= wr_en && (wr_addr == rd_addr);
        vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_q = hit_r ? byp_r : (vld_r ? mem_q_r : REC_RESET);

endmodule

>>> rtl/kdpt_stamp_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// kdpt_stamp_mem
// Per-key press timestamp memory with registered read and
// write-back bypass.
// ============================================================================
module kdpt_stamp_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_q,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);
  import kdpt_pkg::*;

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] mem_q_r;
  logic [W-1:0] byp_r;
  logic         hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      byp_r   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_q = hit_r ? byp_r : mem_q_r;

endmodule

>>> rtl/kdpt_update.sv
`timescale 1ns / 1ps
// ============================================================================
// kdpt_update
// Debounce state transition, press timestamp capture and duration update
// for one key record.
// ============================================================================
module kdpt_update #(
  parameter int TICK_BITS = 32
) (
  input  logic                 func,
  input  logic                 pin_level,
  input  logic [TICK_BITS-1:0] now,
  input  logic [TICK_BITS-1:0] stamp,
  input  kdpt_pkg::kdpt_rec_t  rec,
  output kdpt_pkg::kdpt_upd_t  upd
);
  import kdpt_pkg::*;

  logic                 pressed;
  logic [TICK_BITS-1:0] diff;
  logic [63:0]          diff_w;

  always_comb begin
    pressed      = !pin_level;
    diff         = now - stamp;
    diff_w       = 64'(diff);
    upd.rec      = rec;
    upd.stamp_we = 1'b0;
    upd.ev       = EV_NONE;
    if (func == FUNC_CLEAR) begin
      upd.rec.dur  = '0;
      upd.rec.flag = 1'b0;
    end else begin
      case (rec.st)
        ST_UP: begin
          if (pressed) upd.rec.st = ST_FALLING;
        end
        ST_FALLING: begin
          if (pressed) begin
            upd.rec.st   = ST_DOWN;
            upd.stamp_we = 1'b1;
            upd.ev       = EV_PRESS;
          end else begin
            upd.rec.st = ST_UP;
          end
        end
        ST_DOWN: begin
          if (!pressed) upd.rec.st = ST_RISING;
        end
        ST_RISING: begin
          if (!pressed) begin
            upd.rec.st   = ST_UP;
            upd.rec.dur  = diff_w[DUR_BITS-1:0];
            upd.rec.flag = 1'b1;
            upd.ev       = EV_RELEASE;
          end else begin
            upd.rec.st = ST_DOWN;
          end
        end
        default: begin
          upd.rec.st = ST_UP;
        end
      endcase
    end
  end

endmodule

>>> rtl/key_debounce_press_timer.sv
`timescale 1ns / 1ps
// ============================================================================
// key_debounce_press_timer
// Per-key button debounce machine with press-length timer.
// ============================================================================
// The block takes one item per clock cycle while out_ready does not hold the
// output, and presents its result in the output register after the item has
// passed the read stage. A result held by out_ready low keeps the item behind
// it in the read stage and drops in_ready until the output register frees.
// Per-key state lives in two memories (debounce record and press timestamp)
// with a registered read: an item reads its key at the input transfer and the
// update is written back when the result is loaded into the output register.
// A following item on the same key picks up that write-back through a bypass,
// so items on one key may follow each other with no gap. An item whose key
// index is NUM_KEYS or more changes nothing and reports no event and no
// duration. Records come out of reset in the up state with no duration; no
// clearing pass is needed.
module key_debounce_press_timer #(
  parameter int NUM_KEYS  = 4,
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [1:0]  in_key_index,
  input  logic        in_pin_level,
  input  logic [31:0] in_tick_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_key_event,
  output logic [31:0] out_press_duration,
  output logic        out_duration_valid
);
  import kdpt_pkg::*;

`include "key_debounce_press_timer_macros.svh"

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [6:0]           key_w;
  logic [63:0]          tick_w;
  logic [AW-1:0]        in_addr;
  logic                 in_range;
  logic                 in_xfer;
  logic                 s1_adv;
  logic                 rec_we;
  logic                 stamp_we;
  kdpt_rec_t            rec_q;
  logic [TICK_BITS-1:0] stamp_q;
  kdpt_upd_t            upd;

  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_inr_r;
  logic                 s1_pin_r;
  logic [TICK_BITS-1:0] s1_tick_r;

  logic                 out_valid_r;
  logic [1:0]           out_key_event_r;
  logic [DUR_BITS-1:0]  out_press_duration_r;
  logic                 out_duration_valid_r;

  assign key_w    = {5'b0, in_key_index};
  assign tick_w   = 64'(in_tick_now);
  assign in_addr  = key_w[AW-1:0];
  assign in_range = key_w < 7'(NUM_KEYS);

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign rec_we   = s1_adv && s1_inr_r;
  assign stamp_we = rec_we && upd.stamp_we;

  kdpt_key_mem #(
    .DEPTH (NUM_KEYS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_addr),
    .rd_q    (rec_q),
    .wr_en   (rec_we),
    .wr_addr (s1_addr_r),
    .wr_data (upd.rec)
  );

  kdpt_stamp_mem #(
    .DEPTH (NUM_KEYS),
    .AW    (AW),
    .W     (TICK_BITS)
  ) u_stamp_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_addr),
    .rd_q    (stamp_q),
    .wr_en   (stamp_we),
    .wr_addr (s1_addr_r),
    .wr_data (s1_tick_r)
  );

  kdpt_update #(
    .TICK_BITS (TICK_BITS)
  ) u_update (
    .func      (s1_func_r),
    .pin_level (s1_pin_r),
    .now       (s1_tick_r),
    .stamp     (stamp_q),
    .rec       (rec_q),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= in_func;
      s1_addr_r <= in_addr;
      s1_inr_r  <= in_range;
      s1_pin_r  <= in_pin_level;
      s1_tick_r <= tick_w[TICK_BITS-1:0];
    end
    if (s1_adv) begin
      out_key_event_r      <= s1_inr_r ? upd.ev : EV_NONE;
      out_press_duration_r <= (s1_inr_r && upd.rec.flag) ? upd.rec.dur : '0;
      out_duration_valid_r <= s1_inr_r && upd.rec.flag;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_event      = out_key_event_r;
  assign out_press_duration = out_press_duration_r;
  assign out_duration_valid = out_duration_valid_r;

  `KDPT_ASSERT_SAME(a_release_has_duration, out_valid && (out_key_event == EV_RELEASE),
    out_duration_valid)
  `KDPT_ASSERT_NEXT(a_advance_loads_output, s1_adv, out_valid_r)
  `KDPT_ASSERT_SAME(a_clear_drops_duration, s1_valid_r && (s1_func_r == FUNC_CLEAR),
    (upd.ev == EV_NONE) && !upd.rec.flag && !upd.stamp_we)
  `KDPT_ASSERT_SAME(a_out_of_range_no_write, s1_valid_r && !s1_inr_r, !rec_we && !stamp_we)

endmodule
